// ----- src/bti_pkg.sv -----
// Shared constants and types of the bilinear table interpolator.
// Used by bti_div, bti_mul and the top level; depends on nothing.
`default_nettype none

package bti_pkg;

    // Table geometry
    localparam int MAX_FIRST_POINTS  = 32;
    localparam int MAX_SECOND_POINTS = 32;
    localparam int IDX_W             = 5;
    localparam int GRID_ADDR_W       = 2 * IDX_W;
    localparam int GRID_DEPTH        = MAX_FIRST_POINTS * MAX_SECOND_POINTS;
    localparam int COUNT_W           = 6;
    localparam int DATA_W            = 32;

    // Shared arithmetic widths
    localparam int FRAC_W  = 17;   // Q1.16 weight, 0 .. 65536
    localparam int DIV_W   = 34;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 68;

    localparam logic [FRAC_W-1:0] WEIGHT_ONE = 17'd65536;

    // Command for the multiply-accumulate unit
    typedef struct packed {
        logic vld;
        logic clr;
        logic sh16;
    } mul_cmd_t;

    // Result of the weight divider
    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] frac;
    } div_res_t;

endpackage

`default_nettype wire

// ----- src/bti_div.sv -----
// Iterative weight divider: frac = clamp(trunc(num * 2^16 / den), 0, 2^16).
// One quotient bit per cycle; depends on bti_pkg.
`default_nettype none

module bti_div import bti_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] num,
    input  logic signed [DIV_W-1:0] den,
    output div_res_t                res
);

    logic              run_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [15:0]       quo_reg;
    logic [FRAC_W-1:0] frac_reg;

    logic [DIV_W-1:0]  num_mag;
    logic [DIV_W-1:0]  den_mag;
    logic [DIV_W-1:0]  rem_shift;
    logic              rem_ge;

    // Magnitudes and one restoring step
    always_comb begin
        num_mag   = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
        den_mag   = den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
        rem_shift = {rem_reg[DIV_W-2:0], 1'b0};
        rem_ge    = (rem_shift >= den_reg);
    end

    // Sequence the division
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (num == '0 || num[DIV_W-1] != den[DIV_W-1]) begin
                    frac_reg <= '0;
                    done_reg <= 1'b1;
                end else if (num_mag >= den_mag) begin
                    frac_reg <= WEIGHT_ONE;
                    done_reg <= 1'b1;
                end else begin
                    run_reg <= 1'b1;
                    cnt_reg <= 5'd16;
                    rem_reg <= num_mag;
                    den_reg <= den_mag;
                    quo_reg <= '0;
                end
            end else if (run_reg) begin
                rem_reg <= rem_ge ? (rem_shift - den_reg) : rem_shift;
                quo_reg <= {quo_reg[14:0], rem_ge};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                    frac_reg <= {1'b0, quo_reg[14:0], rem_ge};
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.frac = frac_reg;

endmodule

`default_nettype wire

// ----- src/bti_mul.sv -----
// Shared 34x18 signed multiplier with a product register and a 68-bit accumulator.
// Accumulate happens in the cycle after issue; depends on bti_pkg.
`default_nettype none

module bti_mul import bti_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mul_cmd_t                  cmd,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [ACC_W-1:0]   acc
);

    mul_cmd_t                 cmd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_next;

    // Align the product and add
    always_comb begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (cmd_reg.sh16) begin
            prod_ext = prod_ext <<< 16;
        end
        acc_next = (cmd_reg.clr ? '0 : acc_reg) + prod_ext;
    end

    // Register the command beside the product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg <= '0;
        end else begin
            cmd_reg <= cmd;
        end
    end

    // Multiply and accumulate
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (cmd_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ----- src/bilinear_table_interpolator.sv -----
// Bilinear table interpolator. Loads (first axis point, second axis point, grid value)
// complete in the cycle they are taken. A non-degenerate evaluate beat is shortest
// when both coordinates lie outside the table and longest when both are inside: each
// bracket costs a bisection on the single-read axis memory, a fetch of the spacing and
// for a non-zero spacing the bit-serial weight divider; every non-degenerate evaluate
// then runs a sequence on the shared 34x18 multiplier (the edge blends, cross blend
// and scale). The input is ready again once the result sits in the output register.
`default_nettype none

module bilinear_table_interpolator import bti_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [DATA_W-1:0]        cfg_wdata,
    // request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_func,
    input  logic [IDX_W-1:0]         s_row_index,
    input  logic [IDX_W-1:0]         s_col_index,
    input  logic signed [DATA_W-1:0] s_load_value,
    input  logic signed [DATA_W-1:0] s_query_first,
    input  logic signed [DATA_W-1:0] s_query_second,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_interp_value,
    output logic [1:0]               m_region,
    output logic                     m_saturated,
    output logic                     m_degenerate
);

    localparam logic [1:0] FUNC_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_SECOND = 2'd1;
    localparam logic [1:0] FUNC_LOAD_GRID   = 2'd2;
    localparam logic [1:0] FUNC_EVALUATE    = 2'd3;

    localparam logic [1:0] REGION_INTERIOR   = 2'd0;
    localparam logic [1:0] REGION_FIRST_OUT  = 2'd1;
    localparam logic [1:0] REGION_SECOND_OUT = 2'd2;
    localparam logic [1:0] REGION_CORNER     = 2'd3;

    localparam logic [1:0] CFG_POINTS_FIRST  = 2'd0;
    localparam logic [1:0] CFG_POINTS_SECOND = 2'd1;
    localparam logic [1:0] CFG_SCALE         = 2'd2;

    localparam logic [COUNT_W-1:0] MAX_FIRST_CNT  = COUNT_W'(MAX_FIRST_POINTS);
    localparam logic [COUNT_W-1:0] MAX_SECOND_CNT = COUNT_W'(MAX_SECOND_POINTS);

    localparam logic signed [PROD_W-1:0] P_MAX = 52'sd2147483647;
    localparam logic signed [PROD_W-1:0] P_MIN = -52'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_HI,
        ST_EDGE_LO,
        ST_CLASSIFY,
        ST_SEARCH,
        ST_STEP,
        ST_READ_LO,
        ST_SPAN,
        ST_DIVIDE,
        ST_SETUP,
        ST_MAC,
        ST_OUT
    } state_t;

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                       input logic [COUNT_W-1:0] maxn);
        logic [COUNT_W-1:0] r;
        r = v;
        if (v < COUNT_W'(2)) begin
            r = COUNT_W'(2);
        end else if (v > maxn) begin
            r = maxn;
        end
        return r;
    endfunction

    // Control and configuration
    state_t                   state_reg;
    logic [COUNT_W-1:0]       points_first_reg;
    logic [COUNT_W-1:0]       points_second_reg;
    logic signed [DATA_W-1:0] scale_reg;
    logic                     m_valid_reg;
    logic [3:0]               step_reg;
    logic                     cur_axis_reg;

    // Payload of the evaluation
    logic signed [DATA_W-1:0] q0_reg, q1_reg;
    logic                     ab0_reg, ab1_reg;
    logic [1:0]               region_reg;
    logic                     degen_reg;
    logic [IDX_W-1:0]         lo_reg, hi_reg, mid_reg;
    logic [IDX_W-1:0]         l0_reg, h0_reg, l1_reg, h1_reg;
    logic [IDX_W-1:0]         row_fix_reg, col_fix_reg;
    logic [FRAC_W-1:0]        f0_reg, f1_reg, fa_reg, fb_reg;
    logic signed [DATA_W-1:0] axlo_reg;
    logic [GRID_ADDR_W-1:0]   ga0_reg, ga1_reg, ga2_reg, ga3_reg;
    logic signed [48:0]       a_reg, b_reg;
    logic signed [DATA_W-1:0] z_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic                     res_sat_reg;
    logic signed [DATA_W-1:0] m_interp_value_reg;
    logic [1:0]               m_region_reg;
    logic                     m_saturated_reg;
    logic                     m_degenerate_reg;

    // Memories
    logic signed [DATA_W-1:0] ax0_mem [MAX_FIRST_POINTS];
    logic signed [DATA_W-1:0] ax1_mem [MAX_SECOND_POINTS];
    logic signed [DATA_W-1:0] grid_mem [GRID_DEPTH];
    logic signed [DATA_W-1:0] ax0_rd, ax1_rd, grid_rd;
    logic [IDX_W-1:0]         ax0_raddr, ax1_raddr;
    logic [GRID_ADDR_W-1:0]   grid_raddr;

    // Combinational helpers
    logic                     s_fire;
    logic [IDX_W-1:0]         e0, e1, mid;
    logic                     span_gt1;
    logic signed [DATA_W-1:0] q_sel, rd_sel;
    logic signed [DIV_W-1:0]  span_diff, span_num;
    logic                     be0, be1;
    logic                     div_start;
    div_res_t                 div_res;
    logic                     brk_done;
    logic [FRAC_W-1:0]        brk_frac;
    logic [FRAC_W-1:0]        wa, wb;
    mul_cmd_t                 mul_cmd;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  z_sum, p_sum;
    logic signed [PROD_W-1:0] p_wide;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        e0        = IDX_W'(points_first_reg - COUNT_W'(1));
        e1        = IDX_W'(points_second_reg - COUNT_W'(1));
        mid       = IDX_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
        span_gt1  = (hi_reg - lo_reg) > IDX_W'(1);
        q_sel     = cur_axis_reg ? q1_reg : q0_reg;
        rd_sel    = cur_axis_reg ? ax1_rd : ax0_rd;
        span_diff = {{2{rd_sel[DATA_W-1]}}, rd_sel} - {{2{axlo_reg[DATA_W-1]}}, axlo_reg};
        span_num  = {{2{q_sel[DATA_W-1]}}, q_sel} - {{2{axlo_reg[DATA_W-1]}}, axlo_reg};
        be0       = q0_reg < ax0_rd;
        be1       = q1_reg < ax1_rd;
        div_start = (state_reg == ST_SPAN) && (span_diff != '0);
        brk_done  = ((state_reg == ST_SPAN) && (span_diff == '0)) ||
                    ((state_reg == ST_DIVIDE) && div_res.done);
        brk_frac  = (state_reg == ST_DIVIDE) ? div_res.frac : '0;
        wa        = WEIGHT_ONE - fa_reg;
        wb        = WEIGHT_ONE - fb_reg;
        z_sum     = acc + 68'sh80000000;
        p_sum     = acc + 68'sh8000;
        p_wide    = p_sum[ACC_W-1:16];
    end

    // Axis read addresses
    always_comb begin
        ax0_raddr = '0;
        ax1_raddr = '0;
        unique case (state_reg)
            ST_EDGE_HI: begin
                ax0_raddr = e0;
                ax1_raddr = e1;
            end
            ST_SEARCH: begin
                ax0_raddr = span_gt1 ? mid : lo_reg;
                ax1_raddr = span_gt1 ? mid : lo_reg;
            end
            ST_READ_LO: begin
                ax0_raddr = hi_reg;
                ax1_raddr = hi_reg;
            end
            default: begin
                ax0_raddr = '0;
                ax1_raddr = '0;
            end
        endcase
    end

    // Grid reads and multiplier program
    always_comb begin
        grid_raddr = ga0_reg;
        mul_cmd    = '0;
        mul_a      = '0;
        mul_b      = '0;
        if (state_reg == ST_MAC) begin
            case (step_reg)
                4'd0: grid_raddr = ga0_reg;
                4'd1: begin
                    grid_raddr = ga1_reg;
                    mul_cmd    = '{vld: 1'b1, clr: 1'b1, sh16: 1'b0};
                    mul_a      = {{2{grid_rd[DATA_W-1]}}, grid_rd};
                    mul_b      = {1'b0, wa};
                end
                4'd2: begin
                    grid_raddr = ga2_reg;
                    mul_cmd    = '{vld: 1'b1, clr: 1'b0, sh16: 1'b0};
                    mul_a      = {{2{grid_rd[DATA_W-1]}}, grid_rd};
                    mul_b      = {1'b0, fa_reg};
                end
                4'd3: begin
                    grid_raddr = ga3_reg;
                    mul_cmd    = '{vld: 1'b1, clr: 1'b1, sh16: 1'b0};
                    mul_a      = {{2{grid_rd[DATA_W-1]}}, grid_rd};
                    mul_b      = {1'b0, wa};
                end
                4'd4: begin
                    mul_cmd = '{vld: 1'b1, clr: 1'b0, sh16: 1'b0};
                    mul_a   = {{2{grid_rd[DATA_W-1]}}, grid_rd};
                    mul_b   = {1'b0, fa_reg};
                end
                4'd6: begin
                    mul_cmd = '{vld: 1'b1, clr: 1'b1, sh16: 1'b0};
                    mul_a   = {18'b0, a_reg[15:0]};
                    mul_b   = {1'b0, wb};
                end
                4'd7: begin
                    mul_cmd = '{vld: 1'b1, clr: 1'b0, sh16: 1'b1};
                    mul_a   = {a_reg[48], a_reg[48:16]};
                    mul_b   = {1'b0, wb};
                end
                4'd8: begin
                    mul_cmd = '{vld: 1'b1, clr: 1'b0, sh16: 1'b0};
                    mul_a   = {18'b0, b_reg[15:0]};
                    mul_b   = {1'b0, fb_reg};
                end
                4'd9: begin
                    mul_cmd = '{vld: 1'b1, clr: 1'b0, sh16: 1'b1};
                    mul_a   = {b_reg[48], b_reg[48:16]};
                    mul_b   = {1'b0, fb_reg};
                end
                4'd12: begin
                    mul_cmd = '{vld: 1'b1, clr: 1'b1, sh16: 1'b0};
                    mul_a   = {{2{z_reg[DATA_W-1]}}, z_reg};
                    mul_b   = {2'b0, scale_reg[15:0]};
                end
                4'd13: begin
                    mul_cmd = '{vld: 1'b1, clr: 1'b0, sh16: 1'b1};
                    mul_a   = {{2{z_reg[DATA_W-1]}}, z_reg};
                    mul_b   = {{2{scale_reg[DATA_W-1]}}, scale_reg[31:16]};
                end
                default: begin
                    mul_cmd = '0;
                end
            endcase
        end
    end

    // Axis memories
    always_ff @(posedge aclk) begin
        if (s_fire && s_func == FUNC_LOAD_FIRST) begin
            ax0_mem[s_row_index] <= s_load_value;
        end
        if (s_fire && s_func == FUNC_LOAD_SECOND) begin
            ax1_mem[s_col_index] <= s_load_value;
        end
        ax0_rd <= ax0_mem[ax0_raddr];
        ax1_rd <= ax1_mem[ax1_raddr];
    end

    // Grid memory, row-major
    always_ff @(posedge aclk) begin
        if (s_fire && s_func == FUNC_LOAD_GRID) begin
            grid_mem[{s_row_index, s_col_index}] <= s_load_value;
        end
        grid_rd <= grid_mem[grid_raddr];
    end

    bti_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (span_num),
        .den     (span_diff),
        .res     (div_res)
    );

    bti_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .acc     (acc)
    );

    // Sequencer, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            points_first_reg  <= COUNT_W'(2);
            points_second_reg <= COUNT_W'(2);
            scale_reg         <= 32'sd65536;
            m_valid_reg       <= 1'b0;
            step_reg          <= '0;
            cur_axis_reg      <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_POINTS_FIRST:
                        points_first_reg <= clamp_count(cfg_wdata[COUNT_W-1:0], MAX_FIRST_CNT);
                    CFG_POINTS_SECOND:
                        points_second_reg <= clamp_count(cfg_wdata[COUNT_W-1:0],
                                                         MAX_SECOND_CNT);
                    CFG_SCALE:
                        scale_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // drop the result once taken
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // finish a bracket: keep its indices and weight
            if (brk_done) begin
                if (cur_axis_reg) begin
                    l1_reg <= lo_reg;
                    h1_reg <= hi_reg;
                    f1_reg <= brk_frac;
                end else begin
                    l0_reg <= lo_reg;
                    h0_reg <= hi_reg;
                    f0_reg <= brk_frac;
                end
                if (region_reg == REGION_INTERIOR && !cur_axis_reg) begin
                    cur_axis_reg <= 1'b1;
                    lo_reg       <= '0;
                    hi_reg       <= e1;
                    state_reg    <= ST_SEARCH;
                end else begin
                    state_reg <= ST_SETUP;
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_func == FUNC_EVALUATE) begin
                        q0_reg    <= s_query_first;
                        q1_reg    <= s_query_second;
                        state_reg <= ST_EDGE_HI;
                    end
                end
                ST_EDGE_HI: begin
                    state_reg <= ST_EDGE_LO;
                end
                ST_EDGE_LO: begin
                    ab0_reg   <= q0_reg > ax0_rd;
                    ab1_reg   <= q1_reg > ax1_rd;
                    state_reg <= ST_CLASSIFY;
                end
                ST_CLASSIFY: begin
                    degen_reg <= 1'b0;
                    fa_reg    <= '0;
                    fb_reg    <= '0;
                    lo_reg    <= '0;
                    if ((ab0_reg && ab1_reg) || (ab0_reg && be1) || (be0 && be1) ||
                        (be0 && ab1_reg)) begin
                        // nearest corner, tested in a fixed order
                        region_reg <= REGION_CORNER;
                        step_reg   <= '0;
                        state_reg  <= ST_MAC;
                        if (ab0_reg && ab1_reg) begin
                            ga0_reg <= {e0, e1};
                            ga1_reg <= {e0, e1};
                        end else if (ab0_reg && be1) begin
                            ga0_reg <= {e0, IDX_W'(0)};
                            ga1_reg <= {e0, IDX_W'(0)};
                        end else if (be0 && be1) begin
                            ga0_reg <= '0;
                            ga1_reg <= '0;
                        end else begin
                            ga0_reg <= {IDX_W'(0), e1};
                            ga1_reg <= {IDX_W'(0), e1};
                        end
                    end else if (ab0_reg || be0) begin
                        region_reg   <= REGION_FIRST_OUT;
                        row_fix_reg  <= be0 ? IDX_W'(0) : e0;
                        cur_axis_reg <= 1'b1;
                        hi_reg       <= e1;
                        state_reg    <= ST_SEARCH;
                    end else if (ab1_reg || be1) begin
                        region_reg   <= REGION_SECOND_OUT;
                        col_fix_reg  <= be1 ? IDX_W'(0) : e1;
                        cur_axis_reg <= 1'b0;
                        hi_reg       <= e0;
                        state_reg    <= ST_SEARCH;
                    end else begin
                        region_reg   <= REGION_INTERIOR;
                        cur_axis_reg <= 1'b0;
                        hi_reg       <= e0;
                        state_reg    <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    mid_reg   <= mid;
                    state_reg <= span_gt1 ? ST_STEP : ST_READ_LO;
                end
                ST_STEP: begin
                    // halve the bracket
                    if (rd_sel > q_sel) begin
                        hi_reg <= mid_reg;
                    end else begin
                        lo_reg <= mid_reg;
                    end
                    state_reg <= ST_SEARCH;
                end
                ST_READ_LO: begin
                    axlo_reg  <= rd_sel;
                    state_reg <= ST_SPAN;
                end
                ST_SPAN: begin
                    if (span_diff == '0) begin
                        degen_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: ;
                ST_SETUP: begin
                    step_reg      <= '0;
                    res_value_reg <= '0;
                    res_sat_reg   <= 1'b0;
                    state_reg     <= degen_reg ? ST_OUT : ST_MAC;
                    unique case (region_reg)
                        REGION_FIRST_OUT: begin
                            ga0_reg <= {row_fix_reg, l1_reg};
                            ga1_reg <= {row_fix_reg, h1_reg};
                            fa_reg  <= f1_reg;
                            fb_reg  <= '0;
                        end
                        REGION_SECOND_OUT: begin
                            ga0_reg <= {l0_reg, col_fix_reg};
                            ga1_reg <= {h0_reg, col_fix_reg};
                            fa_reg  <= f0_reg;
                            fb_reg  <= '0;
                        end
                        default: begin
                            ga0_reg <= {l0_reg, l1_reg};
                            ga1_reg <= {h0_reg, l1_reg};
                            fa_reg  <= f0_reg;
                            fb_reg  <= f1_reg;
                        end
                    endcase
                    if (region_reg == REGION_INTERIOR) begin
                        ga2_reg <= {l0_reg, h1_reg};
                        ga3_reg <= {h0_reg, h1_reg};
                    end else if (region_reg == REGION_FIRST_OUT) begin
                        ga2_reg <= {row_fix_reg, l1_reg};
                        ga3_reg <= {row_fix_reg, h1_reg};
                    end else begin
                        ga2_reg <= {l0_reg, col_fix_reg};
                        ga3_reg <= {h0_reg, col_fix_reg};
                    end
                end
                ST_MAC: begin
                    step_reg <= step_reg + 4'd1;
                    // corner: point the unused pair at the same entry
                    if (step_reg == 4'd0 && region_reg == REGION_CORNER) begin
                        ga2_reg <= ga0_reg;
                        ga3_reg <= ga1_reg;
                    end
                    if (step_reg == 4'd4) begin
                        a_reg <= acc[48:0];
                    end
                    if (step_reg == 4'd6) begin
                        b_reg <= acc[48:0];
                    end
                    if (step_reg == 4'd11) begin
                        z_reg <= z_sum[63:32];
                    end
                    if (step_reg == 4'd15) begin
                        // saturate the scaled value
                        if (p_wide > P_MAX) begin
                            res_value_reg <= 32'sh7fffffff;
                            res_sat_reg   <= 1'b1;
                        end else if (p_wide < P_MIN) begin
                            res_value_reg <= 32'sh80000000;
                            res_sat_reg   <= 1'b1;
                        end else begin
                            res_value_reg <= p_wide[DATA_W-1:0];
                            res_sat_reg   <= 1'b0;
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_interp_value_reg <= res_value_reg;
                        m_region_reg       <= region_reg;
                        m_saturated_reg    <= res_sat_reg;
                        m_degenerate_reg   <= degen_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_interp_value = m_interp_value_reg;
    assign m_region       = m_region_reg;
    assign m_saturated    = m_saturated_reg;
    assign m_degenerate   = m_degenerate_reg;

`ifndef SYNTH
    // Point counts stay inside the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (points_first_reg >= COUNT_W'(2)) && (points_first_reg <= MAX_FIRST_CNT) &&
        (points_second_reg >= COUNT_W'(2)) && (points_second_reg <= MAX_SECOND_CNT))
        else $error("point count out of range");

    // Bisection probes strictly inside its bracket
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (lo_reg < mid_reg) && (mid_reg < hi_reg))
        else $error("bisection midpoint outside bracket");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIVIDE))
        else $error("stray divider completion");

    // Degenerate result carries zero and no clip
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_degenerate_reg) |-> (m_interp_value_reg == '0) && !m_saturated_reg)
        else $error("degenerate result not zero");

    // Corner results are never degenerate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_region_reg == REGION_CORNER) |-> !m_degenerate_reg)
        else $error("degenerate corner result");
`endif

endmodule

`default_nettype wire
